// ===== rtl/mpeg_audio_header_parser_macros.svh =====
// assertion macros for the mpeg audio header parser checker
// no dependencies; included by the checker file
`ifndef MPEG_AUDIO_HEADER_PARSER_MACROS_SVH
`define MPEG_AUDIO_HEADER_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MAHP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mahp assertion failed");

// a stalled transfer keeps valid and payload
`define MAHP_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, data) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(data))) \
    else $error("mahp stalled transfer changed");

`endif

// ===== rtl/mahp_pkg.sv =====
// shared types, codes, tables and constants of the mpeg audio header parser
// no dependencies
package mahp_pkg;

  localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

  // version codes
  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_RSVD   = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG1  = 2'd3;

  // layer codes
  localparam logic [1:0] LAYER_RSVD = 2'd0;
  localparam logic [1:0] LAYER_III  = 2'd1;
  localparam logic [1:0] LAYER_II   = 2'd2;
  localparam logic [1:0] LAYER_I    = 2'd3;

  // sample rate index codes
  localparam logic [1:0] SRI_44K1 = 2'd0;
  localparam logic [1:0] SRI_48K  = 2'd1;
  localparam logic [1:0] SRI_32K  = 2'd2;
  localparam logic [1:0] SRI_RSVD = 2'd3;

  localparam logic [1:0] MODE_MONO = 2'd3;

  localparam logic [3:0] BRI_FREE = 4'd0;
  localparam logic [3:0] BRI_BAD  = 4'd15;

  localparam int FB_W   = 12;
  localparam int SR_W   = 16;
  localparam int BR_W   = 9;
  localparam int SPF_W  = 11;
  localparam int CH_W   = 2;
  localparam int COEF_W = 8;
  localparam int N_W    = 17;  // coef * bitrate * rate multiple
  localparam int X_W    = 20;  // dividend, 10 * n for the 44.1k family
  localparam int RCP_W  = 20;
  localparam int RCP_SH = 24;
  localparam int DIV_W  = 9;

  localparam logic [RCP_W-1:0] RCP_44K1 = 20'd38043;   // floor(2^24 / 441)
  localparam logic [RCP_W-1:0] RCP_48K  = 20'd349525;  // floor(2^24 / 48)
  localparam logic [RCP_W-1:0] RCP_32K  = 20'd524288;  // 2^24 / 32, exact
  localparam logic [DIV_W-1:0] DIV_44K1 = 9'd441;
  localparam logic [DIV_W-1:0] DIV_48K  = 9'd48;
  localparam logic [DIV_W-1:0] DIV_32K  = 9'd32;

  typedef logic [BR_W-1:0] br_tab_t [14];

  localparam br_tab_t BR_M1_L1  = '{9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
                                   9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448};
  localparam br_tab_t BR_M1_L2  = '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
                                   9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384};
  localparam br_tab_t BR_M1_L3  = '{9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
                                   9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320};
  localparam br_tab_t BR_M2_L1  = '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
                                   9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256};
  localparam br_tab_t BR_M2_L23 = '{9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
                                   9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160};

  // fields decoded from one header word
  typedef struct packed {
    logic              ok;
    logic              layer_one;
    logic              pad;
    logic [1:0]        ver;
    logic [1:0]        sri;
    logic [COEF_W-1:0] coef;
    logic [BR_W-1:0]   br;
    logic [SR_W-1:0]   sr;
    logic [SPF_W-1:0]  spf;
    logic [CH_W-1:0]   ch;
  } hdr_info_t;

  // fields that ride along the arithmetic stages unchanged
  typedef struct packed {
    logic             ok;
    logic             layer_one;
    logic             pad;
    logic [1:0]       sri;
    logic [BR_W-1:0]  br;
    logic [SR_W-1:0]  sr;
    logic [SPF_W-1:0] spf;
    logic [CH_W-1:0]  ch;
  } carry_t;

  function automatic logic [BR_W-1:0] bitrate_lookup(input logic is_m1,
                                                     input logic [1:0] lay,
                                                     input logic [3:0] bri);
    logic [3:0] t;
    t = bri - 4'd1;
    if (bri == BRI_FREE || bri == BRI_BAD) begin
      return '0;
    end
    if (is_m1) begin
      if (lay == LAYER_I) return BR_M1_L1[t];
      if (lay == LAYER_II) return BR_M1_L2[t];
      return BR_M1_L3[t];
    end
    return (lay == LAYER_I) ? BR_M2_L1[t] : BR_M2_L23[t];
  endfunction

  function automatic logic [RCP_W-1:0] recip_of(input logic [1:0] sri);
    unique case (sri)
      SRI_44K1: return RCP_44K1;
      SRI_48K:  return RCP_48K;
      default:  return RCP_32K;
    endcase
  endfunction

  function automatic logic [DIV_W-1:0] divisor_of(input logic [1:0] sri);
    unique case (sri)
      SRI_44K1: return DIV_44K1;
      SRI_48K:  return DIV_48K;
      default:  return DIV_32K;
    endcase
  endfunction

endpackage

// ===== rtl/mahp_decode.sv =====
// header field decode: checks, version, layer, rates, samples and channels
// depends on mahp_pkg
module mahp_decode import mahp_pkg::*; (
  input  logic [31:0] header_word_i,
  output hdr_info_t   info_o
);

  logic [1:0] ver, lay, sri, mode;
  logic [3:0] bri;
  logic       is_m1;
  logic [SR_W-1:0] base_sr;

  assign ver  = header_word_i[20:19];
  assign lay  = header_word_i[18:17];
  assign bri  = header_word_i[15:12];
  assign sri  = header_word_i[11:10];
  assign mode = header_word_i[7:6];
  assign is_m1 = (ver == VER_MPEG1);

  always_comb begin
    unique case (sri)
      SRI_44K1: base_sr = 16'd44100;
      SRI_48K:  base_sr = 16'd48000;
      default:  base_sr = 16'd32000;
    endcase
  end

  always_comb begin
    info_o.ok = ((header_word_i & SYNC_MASK) == SYNC_MASK) && (ver != VER_RSVD) &&
                (lay != LAYER_RSVD) && (bri != BRI_FREE) && (bri != BRI_BAD) &&
                (sri != SRI_RSVD);
    info_o.layer_one = (lay == LAYER_I);
    info_o.pad = header_word_i[9];
    info_o.ver = ver;
    info_o.sri = sri;
    info_o.br  = bitrate_lookup(is_m1, lay, bri);
    priority if (is_m1) begin
      info_o.sr = base_sr;
    end else if (ver == VER_MPEG2) begin
      info_o.sr = base_sr >> 1;
    end else begin
      info_o.sr = base_sr >> 2;
    end
    priority if (lay == LAYER_I) begin
      info_o.coef = 8'd12;
      info_o.spf  = 11'd384;
    end else if (lay == LAYER_III && !is_m1) begin
      info_o.coef = 8'd72;
      info_o.spf  = 11'd576;
    end else begin
      info_o.coef = 8'd144;
      info_o.spf  = 11'd1152;
    end
    info_o.ch = (mode == MODE_MONO) ? 2'd1 : 2'd2;
  end

endmodule

// ===== rtl/mpeg_audio_header_parser.sv =====
// mpeg audio frame header parser: four-stage pipeline, one header per cycle unless the output stalls
// a header transfer passes through the stage 1, 2, 3 and 4 registers before its result can transfer
// throughput: one header per cycle; each stage holds on a stall and fills bubbles
// frame length uses one 20x20 reciprocal multiply and a one-step correction
// reset (rst_ni low, asynchronous) empties all stage valid bits; payload is not reset
// depends on mahp_pkg and mahp_decode
module mpeg_audio_header_parser import mahp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [31:0]      header_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             valid_res_o,
  output logic [FB_W-1:0]  frame_len_o,
  output logic [SR_W-1:0]  srate_o,
  output logic [BR_W-1:0]  brate_o,
  output logic [SPF_W-1:0] frame_spf_o,
  output logic [CH_W-1:0]  channels_o
);

  // the frame length is floor(coef * br * 1000 / sr) with sr = base / k,
  // k = 1, 2 or 4 by version. that equals floor(n * 1000 / base) with
  // n = coef * br * k, which is n * 10 / 441, n / 48 or n / 32.
  // the quotient is taken by a reciprocal multiply that may fall one short,
  // then fixed by one compare of the remainder against the divisor.

  // stage advance: a stage takes new data when empty or when it drains
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || out_ready_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // stage 1: field decode and table lookups
  hdr_info_t info_d, info_q;

  mahp_decode u_decode (
    .header_word_i (header_word_i),
    .info_o        (info_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) info_q <= info_d;
  end

  // stage 2: dividend n = coef * br * k, times 10 for the 44.1k family
  logic [COEF_W+BR_W-1:0] cb;
  logic [N_W-1:0]         n;
  logic [X_W-1:0]         x2_d, x2_q;
  carry_t                 c1, c2_q;

  assign cb = info_q.coef * info_q.br;

  always_comb begin
    unique case (info_q.ver)
      VER_MPEG1: n = N_W'(cb);
      VER_MPEG2: n = N_W'({cb, 1'b0});
      default:   n = N_W'({cb, 2'b00});
    endcase
  end

  // times ten as (8n + 2n)
  assign x2_d = (info_q.sri == SRI_44K1) ? (X_W'({n, 3'b000}) + X_W'({n, 1'b0}))
                                         : X_W'(n);

  always_comb begin
    c1.ok        = info_q.ok;
    c1.layer_one = info_q.layer_one;
    c1.pad       = info_q.pad;
    c1.sri       = info_q.sri;
    c1.br        = info_q.br;
    c1.sr        = info_q.sr;
    c1.spf       = info_q.spf;
    c1.ch        = info_q.ch;
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      x2_q <= x2_d;
      c2_q <= c1;
    end
  end

  // stage 3: quotient estimate by reciprocal multiply
  logic [X_W+RCP_W-1:0] prod3;
  logic [FB_W-1:0]      qe3_q;
  logic [X_W-1:0]       x3_q;
  carry_t               c3_q;

  assign prod3 = x2_q * recip_of(c2_q.sri);

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      qe3_q <= prod3[RCP_SH +: FB_W];
      x3_q  <= x2_q;
      c3_q  <= c2_q;
    end
  end

  // stage 4: remainder correction, padding and layer i slot scaling
  logic [DIV_W-1:0]      dvs;
  logic [FB_W+DIV_W-1:0] qd;
  logic [X_W-1:0]        rem;
  logic [FB_W-1:0]       q;
  logic [FB_W+1:0]       fb_raw;
  logic                  res_ok;

  assign dvs = divisor_of(c3_q.sri);
  assign qd  = qe3_q * dvs;
  assign rem = x3_q - X_W'(qd);
  assign q   = qe3_q + FB_W'(rem >= X_W'(dvs));

  always_comb begin
    if (c3_q.layer_one) begin
      fb_raw = {(FB_W'(q) + FB_W'(c3_q.pad)), 2'b00};
    end else begin
      fb_raw = (FB_W+2)'(q) + (FB_W+2)'(c3_q.pad);
    end
  end

  // a frame shorter than the header itself is rejected
  assign res_ok = c3_q.ok && (fb_raw >= (FB_W+2)'(4));

  always_ff @(posedge clk_i) begin
    if (adv4 && v3_q) begin
      valid_res_o <= res_ok;
      frame_len_o <= res_ok ? fb_raw[FB_W-1:0] : '0;
      srate_o     <= res_ok ? c3_q.sr : '0;
      brate_o     <= res_ok ? c3_q.br : '0;
      frame_spf_o <= res_ok ? c3_q.spf : '0;
      channels_o  <= res_ok ? c3_q.ch : '0;
    end
  end

  assign out_valid_o = v4_q;

endmodule

// ===== rtl/mahp_checker.sv =====
// port-level checker for the mpeg audio header parser, bound to the top level
// depends on mahp_pkg and mpeg_audio_header_parser_macros.svh
`include "mpeg_audio_header_parser_macros.svh"

module mahp_checker import mahp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             valid_res_o,
  input logic [FB_W-1:0]  frame_len_o,
  input logic [SR_W-1:0]  srate_o,
  input logic [BR_W-1:0]  brate_o,
  input logic [SPF_W-1:0] frame_spf_o,
  input logic [CH_W-1:0]  channels_o
);

  logic res_bad, res_good, fields_zero, fields_set, spf_legal;

  assign res_bad     = out_valid_o && !valid_res_o;
  assign res_good    = out_valid_o && valid_res_o;
  assign fields_zero = (frame_len_o == '0) && (srate_o == '0) && (brate_o == '0) &&
                       (frame_spf_o == '0) && (channels_o == '0);
  assign fields_set  = (frame_len_o >= 12'd4) && (srate_o != '0) && (brate_o != '0) &&
                       (channels_o != '0);
  assign spf_legal   = (frame_spf_o == 11'd384) || (frame_spf_o == 11'd576) ||
                       (frame_spf_o == 11'd1152);

  `MAHP_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i, frame_len_o)
  `MAHP_ASSERT_IMPL(a_bad_zero, clk_i, rst_ni, res_bad, fields_zero)
  `MAHP_ASSERT_IMPL(a_good_nonzero, clk_i, rst_ni, res_good, fields_set)
  `MAHP_ASSERT_IMPL(a_good_spf, clk_i, rst_ni, res_good, spf_legal)

endmodule

bind mpeg_audio_header_parser mahp_checker u_mahp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .valid_res_o (valid_res_o),
  .frame_len_o (frame_len_o),
  .srate_o     (srate_o),
  .brate_o     (brate_o),
  .frame_spf_o (frame_spf_o),
  .channels_o  (channels_o)
);
